// ----- rtl/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and helpers of the linear blend skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int PaletteSize  = 256;
  localparam int Influences   = 4;
  localparam int MaxInfluence = 4;
  localparam int ElemsPerBone = 12;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_POINT = 2'd1,
    FUNC_DIR   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic CFG_BONE_OFFSET   = 1'b0;
  localparam logic CFG_PALETTE_COUNT = 1'b1;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    func_t       func;
    logic [63:0] bone_ids;
    logic [63:0] weights;
    q16_t        vec_x;
    q16_t        vec_y;
    q16_t        vec_z;
    logic [11:0] load_slot;
    q16_t        load_value;
  } item_t;

  typedef struct packed {
    q16_t out_x;
    q16_t out_y;
    q16_t out_z;
    logic influenced;
    logic degenerate;
  } result_t;

  typedef struct packed {
    logic valid;
    logic dir;
    logic influenced;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic            zero;
    logic [2:0]      neg;
    logic [2:0][31:0] res;
    logic [2:0][31:0] mag;
  } norm_side_t;

  function automatic q16_t sat32(input logic signed [67:0] v);
    q16_t r;
    if (v > 68'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -68'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/linear_blend_vertex_skinning_unit.sv -----
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_unit
// Four-influence linear blend skinning with a banked bone-matrix palette.
// ----------------------------------------------------------------------------
// Takes one transaction every cycle while the result side does not stall, and
// returns each position or direction result. A transaction passes 61 register
// stages: the input register and 3 more of palette read and blend, 2 of row
// transform, 5 of scaling and squaring, 32 square-root steps (one root bit
// each), 17 divide steps (one quotient bit each) and the output register.
// Each influence slot reads its own copy of the palette, split in twelve
// element banks, so four full matrices are read per cycle unless stalled; a load
// writes all copies at once. Loads and unused function codes give no result. A
// stall on the result side holds the whole pipeline.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_unit import lbs_pkg::*; #(
  parameter int PALETTE_SIZE = PaletteSize,
  parameter int INFLUENCES   = Influences
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  logic       en;
  logic [7:0] bone_offset;
  logic [8:0] palette_count;
  tag_t       mat_tag;
  q16_t       mat [ElemsPerBone];
  q16_t       mat_vec [3];
  tag_t       res_tag;
  q16_t       res [3];

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_offset   <= '0;
      palette_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BONE_OFFSET:   bone_offset   <= cfg_data[7:0];
        CFG_PALETTE_COUNT: palette_count <= cfg_data;
        default: ;
      endcase
    end
  end

  lbs_blend #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .INFLUENCES   (INFLUENCES)
  ) u_blend (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (item_valid),
    .in_item       (item),
    .bone_offset   (bone_offset),
    .palette_count (palette_count),
    .mat_tag       (mat_tag),
    .mat           (mat),
    .mat_vec       (mat_vec)
  );

  lbs_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .mat_tag (mat_tag),
    .mat     (mat),
    .mat_vec (mat_vec),
    .res_tag (res_tag),
    .res     (res)
  );

  lbs_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .res_tag   (res_tag),
    .res       (res),
    .out_valid (result_valid),
    .out_item  (result)
  );

endmodule

// ----- rtl/lbs_ram.sv -----
// ----------------------------------------------------------------------------
// lbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lbs_blend.sv -----
// ----------------------------------------------------------------------------
// lbs_blend
// Palette banks, influence test and weighted blend of the bone matrices.
// ----------------------------------------------------------------------------
module lbs_blend import lbs_pkg::*; #(
  parameter int PALETTE_SIZE = PaletteSize,
  parameter int INFLUENCES   = Influences
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  item_t      in_item,
  input  logic [7:0] bone_offset,
  input  logic [8:0] palette_count,
  output tag_t       mat_tag,
  output q16_t       mat [ElemsPerBone],
  output q16_t       mat_vec [3]
);

  localparam int AW        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int SlotLimit = PALETTE_SIZE * ElemsPerBone;

  logic        s0_valid;
  item_t       s0_item;

  logic [23:0] slot_mul;
  logic [8:0]  load_bone;
  logic [11:0] load_base;
  logic [3:0]  load_elem;
  logic        load_we;
  logic [AW-1:0] load_addr;

  logic [MaxInfluence-1:0] ok;
  logic [AW-1:0] rd_addr [MaxInfluence];
  q16_t          rd [MaxInfluence][ElemsPerBone];

  tag_t  s1_tag;
  logic [MaxInfluence-1:0] s1_ok;
  logic [MaxInfluence-1:0][15:0] s1_w;
  q16_t  s1_vec [3];

  tag_t  s2_tag;
  logic [MaxInfluence-1:0] s2_ok;
  logic signed [48:0] s2_prod [MaxInfluence][ElemsPerBone];
  q16_t  s2_vec [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
    if (en) begin
      s0_item <= in_item;
    end
  end

  always_comb begin
    slot_mul  = 24'(s0_item.load_slot) * 24'd2731;
    load_bone = slot_mul[23:15];
    load_base = {load_bone, 3'b000} + {1'b0, load_bone, 2'b00};
    load_elem = 4'(s0_item.load_slot - load_base);
    load_addr = AW'(load_bone);
    load_we   = en && s0_valid && (s0_item.func == FUNC_LOAD) &&
                (int'(s0_item.load_slot) < SlotLimit);
  end

  for (genvar b = 0; b < MaxInfluence; b++) begin : g_inf
    if (b < INFLUENCES) begin : g_on
      logic [15:0] raw;
      logic [15:0] w;
      logic [16:0] g;
      assign raw = s0_item.bone_ids[16*b +: 16];
      assign w   = s0_item.weights[16*b +: 16];
      assign g   = 17'(bone_offset) + 17'(raw);
      assign ok[b] = !raw[15] && (w != 16'd0) && (g < 17'(palette_count)) &&
                     (int'(g) < PALETTE_SIZE);
      assign rd_addr[b] = AW'(g);
      for (genvar e = 0; e < ElemsPerBone; e++) begin : g_bank
        lbs_ram #(.WIDTH(32), .DEPTH(PALETTE_SIZE)) u_ram (
          .clk   (clk),
          .we    (load_we && (load_elem == 4'(e))),
          .waddr (load_addr),
          .wdata (s0_item.load_value),
          .re    (en),
          .raddr (rd_addr[b]),
          .rdata (rd[b][e])
        );
      end
    end else begin : g_off
      assign ok[b]      = 1'b0;
      assign rd_addr[b] = '0;
      for (genvar e = 0; e < ElemsPerBone; e++) begin : g_zero
        assign rd[b][e] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
      s2_tag.valid <= 1'b0;
      mat_tag.valid <= 1'b0;
    end else if (en) begin
      s1_tag.valid  <= s0_valid &&
                       (s0_item.func == FUNC_POINT || s0_item.func == FUNC_DIR);
      s2_tag.valid  <= s1_tag.valid;
      mat_tag.valid <= s2_tag.valid;
    end
    if (en) begin
      s1_tag.dir        <= (s0_item.func == FUNC_DIR);
      s1_tag.influenced <= 1'b0;
      s1_ok             <= ok;
      s1_w              <= s0_item.weights;
      s1_vec[0]         <= s0_item.vec_x;
      s1_vec[1]         <= s0_item.vec_y;
      s1_vec[2]         <= s0_item.vec_z;
      s2_tag.dir        <= s1_tag.dir;
      s2_tag.influenced <= |s1_ok;
      s2_ok             <= s1_ok;
      s2_vec            <= s1_vec;
      mat_tag.dir        <= s2_tag.dir;
      mat_tag.influenced <= s2_tag.influenced;
      mat_vec            <= s2_vec;
    end
  end

  for (genvar b = 0; b < MaxInfluence; b++) begin : g_prod
    for (genvar e = 0; e < ElemsPerBone; e++) begin : g_el
      always_ff @(posedge clk) begin
        if (en) begin
          s2_prod[b][e] <= s1_ok[b] ?
                           49'(rd[b][e]) * 49'($signed({1'b0, s1_w[b]})) : '0;
        end
      end
    end
  end

  for (genvar e = 0; e < ElemsPerBone; e++) begin : g_sum
    logic signed [50:0] acc;
    logic signed [50:0] acc_sh;
    q16_t ident;
    assign ident  = (e == 0 || e == 5 || e == 10) ? 32'sd65536 : 32'sd0;
    assign acc    = 51'(s2_prod[0][e]) + 51'(s2_prod[1][e]) + 51'(s2_prod[2][e]) +
                    51'(s2_prod[3][e]) + 51'sd16384;
    assign acc_sh = acc >>> 15;
    always_ff @(posedge clk) begin
      if (en) begin
        mat[e] <= (|s2_ok) ? sat32(68'(acc_sh)) : ident;
      end
    end
  end

endmodule

// ----- rtl/lbs_xform.sv -----
// ----------------------------------------------------------------------------
// lbs_xform
// Row dot products of the blended matrix with the input vector.
// ----------------------------------------------------------------------------
module lbs_xform import lbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  tag_t mat_tag,
  input  q16_t mat [ElemsPerBone],
  input  q16_t mat_vec [3],
  output tag_t res_tag,
  output q16_t res [3]
);

  tag_t x1_tag;
  logic signed [63:0] x1_p [3][3];
  q16_t x1_t [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_tag.valid  <= 1'b0;
      res_tag.valid <= 1'b0;
    end else if (en) begin
      x1_tag.valid  <= mat_tag.valid;
      res_tag.valid <= x1_tag.valid;
    end
    if (en) begin
      x1_tag.dir         <= mat_tag.dir;
      x1_tag.influenced  <= mat_tag.influenced;
      res_tag.dir        <= x1_tag.dir;
      res_tag.influenced <= x1_tag.influenced;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [65:0] sum;
    logic signed [65:0] sum_sh;
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          x1_p[r][j] <= 64'(mat[4*r+j]) * 64'(mat_vec[j]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x1_t[r] <= mat_tag.dir ? 32'sd0 : mat[4*r+3];
      end
    end
    assign sum    = 66'(x1_p[r][0]) + 66'(x1_p[r][1]) + 66'(x1_p[r][2]) +
                    (66'(x1_t[r]) <<< 16) + 66'sd32768;
    assign sum_sh = sum >>> 16;
    always_ff @(posedge clk) begin
      if (en) begin
        res[r] <= sat32(68'(sum_sh));
      end
    end
  end

endmodule

// ----- rtl/lbs_norm.sv -----
// ----------------------------------------------------------------------------
// lbs_norm
// Direction normalize pipeline (positions pass unchanged): scale, sum of
// squares, bitwise square root, restoring divide, and the output register.
// ----------------------------------------------------------------------------
module lbs_norm import lbs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  tag_t    res_tag,
  input  q16_t    res [3],
  output logic    out_valid,
  output result_t out_item
);

  localparam int SqrtSteps = 32;
  localparam int QuoBits   = 17;

  norm_side_t n0_side, n1_side, n2_side, n3_side;
  logic [31:0] n0_max;
  logic [4:0]  n1_k;
  logic [4:0]  k_next;
  logic [31:0] abs_v [3];
  logic [31:0] m01, mx;
  logic [63:0] n3_sq [3];

  norm_side_t    sq_side [SqrtSteps+1];
  logic [63:0]   sq_x    [SqrtSteps+1];
  logic [63:0]   sq_r    [SqrtSteps+1];

  norm_side_t    dv_side [QuoBits+1];
  logic [31:0]   dv_den  [QuoBits+1];
  logic [48:0]   dv_rem  [QuoBits+1][3];
  logic [QuoBits-1:0] dv_q [QuoBits+1][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = res[i][31] ? 32'(-33'(res[i])) : 32'(res[i]);
    end
    m01 = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
    mx  = (m01 > abs_v[2]) ? m01 : abs_v[2];
  end

  always_comb begin
    k_next = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (n0_max[i]) begin
        k_next = 5'(30 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n0_side.tag.valid <= 1'b0;
      n1_side.tag.valid <= 1'b0;
      n2_side.tag.valid <= 1'b0;
      n3_side.tag.valid <= 1'b0;
    end else if (en) begin
      n0_side.tag.valid <= res_tag.valid;
      n1_side.tag.valid <= n0_side.tag.valid;
      n2_side.tag.valid <= n1_side.tag.valid;
      n3_side.tag.valid <= n2_side.tag.valid;
    end
    if (en) begin
      n0_side.tag.dir        <= res_tag.dir;
      n0_side.tag.influenced <= res_tag.influenced;
      n0_side.zero           <= (mx == 32'd0);
      for (int i = 0; i < 3; i++) begin
        n0_side.neg[i] <= res[i][31];
        n0_side.res[i] <= res[i];
        n0_side.mag[i] <= abs_v[i];
      end
      n0_max <= mx;
      n1_side.tag.dir        <= n0_side.tag.dir;
      n1_side.tag.influenced <= n0_side.tag.influenced;
      n1_side.zero <= n0_side.zero;
      n1_side.neg  <= n0_side.neg;
      n1_side.res  <= n0_side.res;
      n1_side.mag  <= n0_side.mag;
      n1_k         <= k_next;
      n2_side.tag.dir        <= n1_side.tag.dir;
      n2_side.tag.influenced <= n1_side.tag.influenced;
      n2_side.zero <= n1_side.zero;
      n2_side.neg  <= n1_side.neg;
      n2_side.res  <= n1_side.res;
      for (int i = 0; i < 3; i++) begin
        n2_side.mag[i] <= n1_side.mag[i] << n1_k;
      end
      n3_side.tag.dir        <= n2_side.tag.dir;
      n3_side.tag.influenced <= n2_side.tag.influenced;
      n3_side.zero <= n2_side.zero;
      n3_side.neg  <= n2_side.neg;
      n3_side.res  <= n2_side.res;
      n3_side.mag  <= n2_side.mag;
      for (int i = 0; i < 3; i++) begin
        n3_sq[i] <= 64'(n2_side.mag[i]) * 64'(n2_side.mag[i]);
      end
    end
  end

  // sum of squares feeds the first root step
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0].tag.valid <= 1'b0;
    end else if (en) begin
      sq_side[0].tag.valid <= n3_side.tag.valid;
    end
    if (en) begin
      sq_side[0].tag.dir        <= n3_side.tag.dir;
      sq_side[0].tag.influenced <= n3_side.tag.influenced;
      sq_side[0].zero <= n3_side.zero;
      sq_side[0].neg  <= n3_side.neg;
      sq_side[0].res  <= n3_side.res;
      sq_side[0].mag  <= n3_side.mag;
      sq_x[0]         <= n3_sq[0] + n3_sq[1] + n3_sq[2];
    end
  end
  assign sq_r[0] = 64'd0;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        take;
    logic [63:0] r_in;
    if (i == 0) begin : g_first
      assign r_in = 64'd0;
    end else begin : g_rest
      assign r_in = sq_r[i];
    end
    assign trial = r_in + StepBit;
    assign take  = (sq_x[i] >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[i+1].tag.valid <= 1'b0;
      end else if (en) begin
        sq_side[i+1].tag.valid <= sq_side[i].tag.valid;
      end
      if (en) begin
        sq_side[i+1].tag.dir        <= sq_side[i].tag.dir;
        sq_side[i+1].tag.influenced <= sq_side[i].tag.influenced;
        sq_side[i+1].zero <= sq_side[i].zero;
        sq_side[i+1].neg  <= sq_side[i].neg;
        sq_side[i+1].res  <= sq_side[i].res;
        sq_side[i+1].mag  <= sq_side[i].mag;
        sq_x[i+1] <= take ? (sq_x[i] - trial) : sq_x[i];
        sq_r[i+1] <= take ? ((r_in >> 1) + StepBit) : (r_in >> 1);
      end
    end
  end

  assign dv_side[0] = sq_side[SqrtSteps];
  assign dv_den[0]  = sq_r[SqrtSteps][31:0];
  for (genvar c = 0; c < 3; c++) begin : g_dv0
    assign dv_rem[0][c] = {1'b0, sq_side[SqrtSteps].mag[c], 16'd0} +
                          49'(sq_r[SqrtSteps][31:1]);
    assign dv_q[0][c]   = '0;
  end

  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    localparam int Sh = QuoBits - 1 - k;
    logic [48:0] trial [3];
    logic [2:0]  take;
    for (genvar c = 0; c < 3; c++) begin : g_lane
      assign trial[c] = 49'(dv_den[k]) << Sh;
      assign take[c]  = (dv_rem[k][c] >= trial[c]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_side[k+1].tag.valid <= 1'b0;
      end else if (en) begin
        dv_side[k+1].tag.valid <= dv_side[k].tag.valid;
      end
      if (en) begin
        dv_side[k+1].tag.dir        <= dv_side[k].tag.dir;
        dv_side[k+1].tag.influenced <= dv_side[k].tag.influenced;
        dv_side[k+1].zero <= dv_side[k].zero;
        dv_side[k+1].neg  <= dv_side[k].neg;
        dv_side[k+1].res  <= dv_side[k].res;
        dv_side[k+1].mag  <= dv_side[k].mag;
        dv_den[k+1]       <= dv_den[k];
        for (int c = 0; c < 3; c++) begin
          dv_rem[k+1][c] <= take[c] ? (dv_rem[k][c] - trial[c]) : dv_rem[k][c];
          dv_q[k+1][c]   <= dv_q[k][c] | (QuoBits'(take[c]) << Sh);
        end
      end
    end
  end

  q16_t nrm [3];
  for (genvar c = 0; c < 3; c++) begin : g_sign
    assign nrm[c] = dv_side[QuoBits].neg[c] ? -32'(dv_q[QuoBits][c])
                                            : 32'(dv_q[QuoBits][c]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_side[QuoBits].tag.valid;
    end
    if (en) begin
      out_item.influenced <= dv_side[QuoBits].tag.influenced;
      if (!dv_side[QuoBits].tag.dir) begin
        out_item.out_x      <= dv_side[QuoBits].res[0];
        out_item.out_y      <= dv_side[QuoBits].res[1];
        out_item.out_z      <= dv_side[QuoBits].res[2];
        out_item.degenerate <= 1'b0;
      end else if (dv_side[QuoBits].zero) begin
        out_item.out_x      <= '0;
        out_item.out_y      <= '0;
        out_item.out_z      <= '0;
        out_item.degenerate <= 1'b1;
      end else begin
        out_item.out_x      <= nrm[0];
        out_item.out_y      <= nrm[1];
        out_item.out_z      <= nrm[2];
        out_item.degenerate <= 1'b0;
      end
    end
  end

endmodule
